### src/rrnr_pkg.sv
// Shared types and constants for the round-robin node router.
// No dependencies; used by rrnr_rem and round_robin_node_router.
package rrnr_pkg;

    // Request kinds.
    localparam logic REQ_REGISTER = 1'b0;
    localparam logic REQ_CHOOSE   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BLANK = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Width of the fixed key fields on the ports.
    localparam int FIELD_W = 16;

    // Round-robin cursors are 32 bits and wrap.
    localparam int CUR_W  = 32;
    localparam int STEP_W = $clog2(CUR_W);

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

### src/rrnr_rem.sv
// Bit-serial remainder unit: cursor modulo node count, one quotient bit a cycle.
// Depends on rrnr_pkg.
module rrnr_rem #(
    parameter int CNT_W = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rrnr_pkg::CUR_W-1:0] dividend,
    input  logic [CNT_W-1:0]         divisor,
    output rrnr_pkg::rem_stat_t      stat,
    output logic [CNT_W-1:0]         remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [rrnr_pkg::STEP_W-1:0]   step_reg;
    logic [rrnr_pkg::CUR_W-1:0]    quo_reg;
    logic [CNT_W-1:0]              rem_reg;
    logic [CNT_W-1:0]              div_reg;
    logic [CNT_W:0]                trial;
    logic [CNT_W:0]                diff;
    logic [CNT_W-1:0]              rem_next;

    // The partial remainder stays below the divisor, so the shifted trial
    // value fits in one extra bit and one subtraction restores it.
    always_comb begin
        trial = {rem_reg, quo_reg[rrnr_pkg::CUR_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg}) begin
            rem_next = diff[CNT_W-1:0];
        end else begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == rrnr_pkg::STEP_W'(rrnr_pkg::CUR_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[rrnr_pkg::CUR_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

### src/round_robin_node_router.sv
// Round-robin node router: sequencer with model key, node count, cursor and node memories.
// Depends on rrnr_pkg and rrnr_rem. One request is in flight at a time; a register scans the
// model keys and then the node list, a choose scans the model keys and, when the model has
// nodes, waits for the remainder unit; blank or null-mode requests go straight to the response.
// Synchronous reset (aresetn low) clears the state, output valid, model count and null mode; memories are not.
module round_robin_node_router #(
    parameter int MAX_MODELS = 16,
    parameter int MAX_NODES  = 8,
    parameter int ID_BITS    = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_null_mode,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [rrnr_pkg::FIELD_W-1:0]   s_model_key,
    input  logic [rrnr_pkg::FIELD_W-1:0]   s_node_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic                           m_node_valid,
    output logic [rrnr_pkg::FIELD_W-1:0]   m_chosen_node
);

    localparam int KEY_W = (ID_BITS < rrnr_pkg::FIELD_W) ? ID_BITS : rrnr_pkg::FIELD_W;
    localparam int MC_W  = $clog2(MAX_MODELS + 1);
    localparam int MI_W  = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int TD    = MAX_MODELS * MAX_NODES;
    localparam int TA_W  = (TD > 1) ? $clog2(TD) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRD  = 4'd1;
    localparam logic [3:0] S_MCMP = 4'd2;
    localparam logic [3:0] S_CRD  = 4'd3;
    localparam logic [3:0] S_CGOT = 4'd4;
    localparam logic [3:0] S_NRD  = 4'd5;
    localparam logic [3:0] S_NCMP = 4'd6;
    localparam logic [3:0] S_MODW = 4'd7;
    localparam logic [3:0] S_PRD  = 4'd8;
    localparam logic [3:0] S_PGOT = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]                  state_reg, state_next;
    logic                        null_mode_reg;
    logic [MC_W-1:0]             models_used_reg, models_used_next;
    logic [MC_W-1:0]             scan_reg, scan_next;
    logic [MI_W-1:0]             idx_reg, idx_next;
    logic [TA_W-1:0]             base_reg, base_next;
    logic [NC_W-1:0]             off_reg, off_next;
    logic [NC_W-1:0]             cnt_reg, cnt_next;
    logic [rrnr_pkg::CUR_W-1:0]  cur_reg, cur_next;
    logic                        req_reg, req_next;
    logic [KEY_W-1:0]            mkey_reg, mkey_next;
    logic [KEY_W-1:0]            nkey_reg, nkey_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic                        res_valid_reg, res_valid_next;
    logic [KEY_W-1:0]            res_node_reg, res_node_next;
    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  m_status_reg, m_status_next;
    logic                        m_node_valid_reg, m_node_valid_next;
    logic [KEY_W-1:0]            m_chosen_reg, m_chosen_next;

    logic                        create;
    logic                        node_add;
    logic                        cur_adv;
    logic                        rem_start;
    logic [KEY_W-1:0]            mkey_in;
    logic [KEY_W-1:0]            nkey_in;
    logic [TA_W-1:0]             node_addr;
    logic [MI_W-1:0]             entry_wa;

    logic [KEY_W-1:0]            key_mem  [MAX_MODELS];
    logic [NC_W-1:0]             cnt_mem  [MAX_MODELS];
    logic [rrnr_pkg::CUR_W-1:0]  cur_mem  [MAX_MODELS];
    logic [KEY_W-1:0]            node_mem [TD];
    logic [KEY_W-1:0]            key_rd_reg;
    logic [NC_W-1:0]             cnt_rd_reg;
    logic [rrnr_pkg::CUR_W-1:0]  cur_rd_reg;
    logic [KEY_W-1:0]            node_rd_reg;

    rrnr_pkg::rem_stat_t         rem_stat;
    logic [NC_W-1:0]             rem_val;

    rrnr_rem #(
        .CNT_W(NC_W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (cur_rd_reg),
        .divisor   (cnt_rd_reg),
        .stat      (rem_stat),
        .remainder (rem_val)
    );

    // Keys are compared and stored in their low KEY_W bits (ID_BITS, at most FIELD_W).
    assign mkey_in   = s_model_key[KEY_W-1:0];
    assign nkey_in   = s_node_key[KEY_W-1:0];
    assign node_addr = base_reg + TA_W'(off_reg);
    assign entry_wa  = create ? models_used_reg[MI_W-1:0] : idx_reg;

    always_comb begin
        state_next        = state_reg;
        models_used_next  = models_used_reg;
        scan_next         = scan_reg;
        idx_next          = idx_reg;
        base_next         = base_reg;
        off_next          = off_reg;
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        req_next          = req_reg;
        mkey_next         = mkey_reg;
        nkey_next         = nkey_reg;
        res_status_next   = res_status_reg;
        res_valid_next    = res_valid_reg;
        res_node_next     = res_node_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_node_valid_next = m_node_valid_reg;
        m_chosen_next     = m_chosen_reg;
        create            = 1'b0;
        node_add          = 1'b0;
        cur_adv           = 1'b0;
        rem_start         = 1'b0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = s_req_type;
                    mkey_next       = mkey_in;
                    nkey_next       = nkey_in;
                    res_status_next = rrnr_pkg::ST_OK;
                    res_valid_next  = 1'b0;
                    res_node_next   = '0;
                    scan_next       = '0;
                    if (mkey_in == '0 ||
                        (s_req_type == rrnr_pkg::REQ_REGISTER && nkey_in == '0)) begin
                        res_status_next = rrnr_pkg::ST_BLANK;
                        state_next      = S_RESP;
                    end else if (null_mode_reg) begin
                        state_next = S_RESP;
                    end else begin
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD: begin
                if (scan_reg == models_used_reg) begin
                    // Model not listed yet.
                    if (req_reg == rrnr_pkg::REQ_CHOOSE) begin
                        state_next = S_RESP;
                    end else if (models_used_reg == MC_W'(MAX_MODELS)) begin
                        res_status_next = rrnr_pkg::ST_FULL;
                        state_next      = S_RESP;
                    end else begin
                        create           = 1'b1;
                        idx_next         = models_used_reg[MI_W-1:0];
                        models_used_next = models_used_reg + 1'b1;
                        state_next       = S_CRD;
                    end
                end else begin
                    state_next = S_MCMP;
                end
            end
            S_MCMP: begin
                if (key_rd_reg == mkey_reg) begin
                    idx_next   = scan_reg[MI_W-1:0];
                    state_next = S_CRD;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_MRD;
                end
            end
            S_CRD: begin
                base_next  = TA_W'(idx_reg) * TA_W'(MAX_NODES);
                state_next = S_CGOT;
            end
            S_CGOT: begin
                cnt_next = cnt_rd_reg;
                cur_next = cur_rd_reg;
                off_next = '0;
                if (req_reg == rrnr_pkg::REQ_REGISTER) begin
                    state_next = S_NRD;
                end else if (cnt_rd_reg == '0) begin
                    state_next = S_RESP;
                end else begin
                    rem_start  = 1'b1;
                    state_next = S_MODW;
                end
            end
            S_NRD: begin
                if (off_reg == cnt_reg) begin
                    if (cnt_reg == NC_W'(MAX_NODES)) begin
                        res_status_next = rrnr_pkg::ST_FULL;
                    end else begin
                        node_add = 1'b1;
                    end
                    state_next = S_RESP;
                end else begin
                    state_next = S_NCMP;
                end
            end
            S_NCMP: begin
                // A node that is already listed counts as success.
                if (node_rd_reg == nkey_reg) begin
                    state_next = S_RESP;
                end else begin
                    off_next   = off_reg + 1'b1;
                    state_next = S_NRD;
                end
            end
            S_MODW: begin
                if (rem_stat.done) begin
                    off_next   = rem_val;
                    cur_adv    = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_PRD: begin
                state_next = S_PGOT;
            end
            S_PGOT: begin
                res_valid_next = 1'b1;
                res_node_next  = node_rd_reg;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_node_valid_next = res_valid_reg;
                    m_chosen_next     = res_node_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            models_used_reg <= '0;
            m_valid_reg     <= 1'b0;
            null_mode_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            models_used_reg <= models_used_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid) begin
                null_mode_reg <= cfg_null_mode;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg         <= scan_next;
        idx_reg          <= idx_next;
        base_reg         <= base_next;
        off_reg          <= off_next;
        cnt_reg          <= cnt_next;
        cur_reg          <= cur_next;
        req_reg          <= req_next;
        mkey_reg         <= mkey_next;
        nkey_reg         <= nkey_next;
        res_status_reg   <= res_status_next;
        res_valid_reg    <= res_valid_next;
        res_node_reg     <= res_node_next;
        m_status_reg     <= m_status_next;
        m_node_valid_reg <= m_node_valid_next;
        m_chosen_reg     <= m_chosen_next;
    end

    // Per-model memories, all read at registered addresses every cycle.
    always_ff @(posedge aclk) begin
        if (create) begin
            key_mem[entry_wa] <= mkey_reg;
        end
        key_rd_reg <= key_mem[scan_reg[MI_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (create) begin
            cnt_mem[entry_wa] <= '0;
        end else if (node_add) begin
            cnt_mem[entry_wa] <= cnt_reg + 1'b1;
        end
        cnt_rd_reg <= cnt_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (create) begin
            cur_mem[entry_wa] <= '0;
        end else if (cur_adv) begin
            cur_mem[entry_wa] <= cur_reg + 1'b1;
        end
        cur_rd_reg <= cur_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (node_add) begin
            node_mem[node_addr] <= nkey_reg;
        end
        node_rd_reg <= node_mem[node_addr];
    end

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_node_valid  = m_node_valid_reg;
    assign m_chosen_node = rrnr_pkg::FIELD_W'(m_chosen_reg);

`ifndef SYNTHESIS
    // The remainder unit only runs while the sequencer waits for it.
    a_rem_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_stat.busy |-> state_reg == S_MODW)
        else $error("remainder unit busy outside its wait state");

    a_model_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        models_used_reg <= MC_W'(MAX_MODELS))
        else $error("model count beyond table size");

    // A returned node is always a stored, non-blank identifier with status ok.
    a_node_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_node_valid |-> m_status == rrnr_pkg::ST_OK && m_chosen_node != '0)
        else $error("chosen node with bad status or blank identifier");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for round_robin_node_router: directed and random requests
// are checked against a scoreboard that predicts the router's tables and cursors.
// Depends on rrnr_pkg and round_robin_node_router.
`timescale 1ns / 1ps

module testbench;

    localparam int MODELS      = 16;
    localparam int NODES       = 8;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 250;

    typedef logic [rrnr_pkg::FIELD_W-1:0] key_t;

    typedef struct packed {
        logic [1:0] status;
        logic       node_valid;
        key_t       chosen_node;
    } route_result_t;

    class router_scoreboard;
        bit                         null_mode;
        int unsigned                models_used;
        key_t                       model_keys[MODELS];
        int unsigned                node_counts[MODELS];
        key_t                       node_lists[MODELS][NODES];
        logic [rrnr_pkg::CUR_W-1:0] cursors[MODELS];
        route_result_t              routes_due[$];
        int                         errors;

        function void set_null_mode(bit value);
            null_mode = value;
        endfunction

        function int pending();
            return routes_due.size();
        endfunction

        // Works out the answer to one accepted request and updates the tables.
        function void note_request(logic req, key_t mk, key_t nk);
            route_result_t res;
            int            slot;
            bit            dup;
            res.status      = rrnr_pkg::ST_OK;
            res.node_valid  = 1'b0;
            res.chosen_node = '0;
            slot = -1;
            for (int i = 0; i < models_used; i++)
                if (model_keys[i] == mk)
                    slot = i;
            if (req == rrnr_pkg::REQ_REGISTER) begin
                if (mk == 0 || nk == 0) begin
                    res.status = rrnr_pkg::ST_BLANK;
                end else if (!null_mode) begin
                    if (slot < 0 && models_used >= MODELS) begin
                        res.status = rrnr_pkg::ST_FULL;
                    end else begin
                        if (slot < 0) begin
                            slot              = models_used;
                            model_keys[slot]  = mk;
                            node_counts[slot] = 0;
                            cursors[slot]     = '0;
                            models_used++;
                        end
                        dup = 1'b0;
                        for (int j = 0; j < node_counts[slot]; j++)
                            if (node_lists[slot][j] == nk)
                                dup = 1'b1;
                        if (!dup) begin
                            if (node_counts[slot] >= NODES) begin
                                res.status = rrnr_pkg::ST_FULL;
                            end else begin
                                node_lists[slot][node_counts[slot]] = nk;
                                node_counts[slot]++;
                            end
                        end
                    end
                end
            end else begin
                if (mk == 0) begin
                    res.status = rrnr_pkg::ST_BLANK;
                end else if (!null_mode && slot >= 0 && node_counts[slot] != 0) begin
                    res.node_valid  = 1'b1;
                    res.chosen_node = node_lists[slot][cursors[slot] % node_counts[slot]];
                    cursors[slot]   = cursors[slot] + 1;
                end
            end
            routes_due.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic node_valid, key_t chosen_node);
            route_result_t want;
            if (routes_due.size() == 0) begin
                $error("result beat arrived with no request outstanding");
                errors++;
                return;
            end
            want = routes_due.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                errors++;
            end
            if (node_valid !== want.node_valid) begin
                $error("node_valid: expected %0d, actual %0d", want.node_valid, node_valid);
                errors++;
            end
            if (chosen_node !== want.chosen_node) begin
                $error("chosen_node: expected %0h, actual %0h", want.chosen_node, chosen_node);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_null_mode = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic       s_req_type    = rrnr_pkg::REQ_REGISTER;
    key_t       s_model_key   = '0;
    key_t       s_node_key    = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [1:0] m_status;
    logic       m_node_valid;
    key_t       m_chosen_node;

    router_scoreboard board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    key_t model_pool[20];
    key_t node_pool[12];

    round_robin_node_router #(
        .MAX_MODELS(MODELS),
        .MAX_NODES (NODES),
        .ID_BITS   (rrnr_pkg::FIELD_W)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_null_mode(cfg_null_mode),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_model_key  (s_model_key),
        .s_node_key   (s_node_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_node_valid (m_node_valid),
        .m_chosen_node(m_chosen_node)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready = 1'b0;
        else
            m_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_status, m_node_valid, m_chosen_node);
    end

    // Any beat on any channel counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input logic req, input key_t mk, input key_t nk);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_req_type  = req;
        s_model_key = mk;
        s_node_key  = nk;
        do @(posedge aclk); while (!s_ready);
        board.note_request(req, mk, nk);
    endtask

    // Stops sending and waits until every outstanding result beat has been taken.
    task automatic drain;
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_null_mode(input logic value);
        @(negedge aclk);
        cfg_valid     = 1'b1;
        cfg_null_mode = value;
        do @(posedge aclk); while (!cfg_ready);
        board.set_null_mode(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int count);
        int   pick;
        int   m;
        logic req;
        key_t mk;
        key_t nk;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            m    = $urandom_range(19);
            if (pick < 45) begin
                // Each model draws from a node pool of its own size, so that lists
                // settle at different lengths and some of them overflow.
                req = rrnr_pkg::REQ_REGISTER;
                mk  = model_pool[m];
                nk  = node_pool[$urandom_range(m % 12)];
            end else if (pick < 85) begin
                req = rrnr_pkg::REQ_CHOOSE;
                mk  = model_pool[m];
                nk  = key_t'($urandom);
            end else begin
                req = ($urandom_range(1) == 0) ? rrnr_pkg::REQ_REGISTER : rrnr_pkg::REQ_CHOOSE;
                mk  = ($urandom_range(3) == 0) ? key_t'(0) : key_t'($urandom);
                nk  = ($urandom_range(3) == 0) ? key_t'(0) : key_t'($urandom);
            end
            send_request(req, mk, nk);
        end
    endtask

    initial begin
        foreach (model_pool[i])
            model_pool[i] = key_t'($urandom_range(65535, 1));
        foreach (node_pool[i])
            node_pool[i] = key_t'($urandom_range(65535, 1));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_null_mode(1'b0);
        send_request(rrnr_pkg::REQ_CHOOSE,   16'h0000, 16'h5a5a);
        send_request(rrnr_pkg::REQ_REGISTER, 16'h0000, 16'h0001);
        send_request(rrnr_pkg::REQ_REGISTER, 16'hffff, 16'h0000);
        send_request(rrnr_pkg::REQ_CHOOSE,   16'h1234, 16'h0000);
        send_request(rrnr_pkg::REQ_REGISTER, 16'hffff, 16'hffff);
        send_request(rrnr_pkg::REQ_REGISTER, 16'hffff, 16'h0001);
        send_request(rrnr_pkg::REQ_REGISTER, 16'hffff, 16'hffff);
        send_request(rrnr_pkg::REQ_REGISTER, 16'hffff, 16'h8000);
        repeat (4) send_request(rrnr_pkg::REQ_CHOOSE, 16'hffff, 16'h0000);
        send_request(rrnr_pkg::REQ_REGISTER, 16'h0001, 16'h7fff);
        send_request(rrnr_pkg::REQ_CHOOSE,   16'h0001, 16'hffff);
        drain();

        write_null_mode(1'b1);
        send_request(rrnr_pkg::REQ_REGISTER, 16'h2222, 16'h0005);
        send_request(rrnr_pkg::REQ_CHOOSE,   16'hffff, 16'h0000);
        send_request(rrnr_pkg::REQ_REGISTER, 16'h0000, 16'h0000);
        send_request(rrnr_pkg::REQ_CHOOSE,   16'h0000, 16'h0000);
        drain();

        write_null_mode(1'b0);
        send_request(rrnr_pkg::REQ_CHOOSE, 16'h2222, 16'h0000);
        send_request(rrnr_pkg::REQ_CHOOSE, 16'hffff, 16'h0000);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            write_null_mode((phase == 1 || phase == 6) ? 1'b1 : 1'b0);
            run_random(PHASE_ITEMS);
            drain();
        end

        repeat (100) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
